[hdl/pip_pkg.sv]
// Package for the point-in-polygon tester.
// Holds the shared constants, register indexes and controller/datapath structs.
// No dependencies.
package pip_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 32;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_VERTEX_COUNT    = 2'd0;
  localparam logic [1:0] REG_CROSS_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_COORD_TOLERANCE = 2'd2;

  // Register widths and reset values.
  localparam int VCOUNT_W = 7;
  localparam int XTOL_W   = 32;
  localparam int CTOL_W   = 16;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = '0;
  localparam logic [XTOL_W-1:0]   XTOL_RST   = 32'd429497;
  localparam logic [CTOL_W-1:0]   CTOL_RST   = 16'd7;

  // Input item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;   // write the input vertex into the store
    logic q_start;   // latch the query point and clear the accumulators
    logic rd_en;     // read one vertex from the store
    logic rd_first;  // the vertex read is vertex zero
    logic wrap;      // closing edge from the last vertex back to vertex zero
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;  // an edge is still in flight
    logic inside_res; // accumulated inside answer
    logic on_edge;    // accumulated on-edge answer
  } sts_t;

endpackage

[hdl/pip_ctrl.sv]
// Controller of the point-in-polygon tester: handshake, edge walk sequencing
// and the result register. Depends on pip_pkg.
module pip_ctrl #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  localparam int AW = $clog2(MAX_VERTICES),
  localparam int NW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_inside_res,
  output logic                out_on_edge,
  input  logic [NW-1:0]       vcount,
  output logic [AW-1:0]       rd_addr,
  output pip_pkg::cmd_t       cmd,
  input  pip_pkg::sts_t       sts
);

  typedef enum logic [2:0] {IDLE, WALK, WRAP, DRAIN, FIN} state_t;

  state_t        state_r;
  logic [NW-1:0] k_r;
  logic          out_valid_r;
  logic          inside_r;
  logic          on_edge_r;
  logic          accept;

  assign in_stall       = (state_r != IDLE);
  assign accept         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;
  assign out_on_edge    = on_edge_r;
  assign rd_addr        = k_r[AW-1:0];

  // Command decode from the current state.
  always_comb begin
    cmd          = '0;
    cmd.load_we  = accept && (in_kind == pip_pkg::KIND_LOAD);
    cmd.q_start  = accept && (in_kind == pip_pkg::KIND_QUERY);
    cmd.rd_en    = (state_r == WALK);
    cmd.rd_first = (state_r == WALK) && (k_r == '0);
    cmd.wrap     = (state_r == WRAP);
  end

  // State, walk counter and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In FIN the result register is refilled instead of emptied.
      if (out_valid_r && !out_stall && (state_r != FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (cmd.q_start) begin
            k_r     <= '0;
            state_r <= (vcount == '0) ? FIN : WALK;
          end
        end
        WALK: begin
          if (k_r == vcount - NW'(1)) begin
            state_r <= WRAP;
          end else begin
            k_r <= k_r + NW'(1);
          end
        end
        WRAP: begin
          state_r <= DRAIN;
        end
        DRAIN: begin
          if (!sts.pipe_busy) begin
            state_r <= FIN;
          end
        end
        FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            inside_r    <= sts.inside_res;
            on_edge_r   <= sts.on_edge;
            state_r     <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/pip_dp.sv]
// Datapath of the point-in-polygon tester: vertex store, edge pipeline with
// the cross products, tolerance tests and the crossing parity. Depends on pip_pkg.
module pip_dp #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [5:0]                  in_vertex_index,
  input  logic signed [31:0]          in_coord_x,
  input  logic signed [31:0]          in_coord_y,
  input  logic [AW-1:0]               rd_addr,
  input  logic [pip_pkg::XTOL_W-1:0]  cross_tol,
  input  logic [pip_pkg::CTOL_W-1:0]  coord_tol,
  input  pip_pkg::cmd_t               cmd,
  output pip_pkg::sts_t               sts
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;          // coordinate difference
  localparam int PW = 2 * DW;          // product
  localparam int QW = PW + 1;          // product difference
  localparam int XW = (QW > 33) ? QW : 33;
  localparam int EW = 34;

  // Vertex store.
  logic signed [CW-1:0] mem_x [MAX_VERTICES];
  logic signed [CW-1:0] mem_y [MAX_VERTICES];
  logic signed [CW-1:0] rd_x_r, rd_y_r;

  logic signed [CW-1:0] in_x, in_y;
  logic                 slot_ok;

  assign in_x    = in_coord_x[CW-1:0];
  assign in_y    = in_coord_y[CW-1:0];
  assign slot_ok = (int'(in_vertex_index) < MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (cmd.load_we && slot_ok) begin
      mem_x[AW'(in_vertex_index)] <= in_x;
      mem_y[AW'(in_vertex_index)] <= in_y;
    end
    if (cmd.rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  // Query point and the vertices kept across the walk.
  logic signed [CW-1:0] px_r, py_r, prev_x_r, prev_y_r, first_x_r, first_y_r;
  logic m_vld_r, m_first_r, m_wrap_r;

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      px_r <= in_x;
      py_r <= in_y;
    end
    if (m_vld_r && !m_wrap_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
      if (m_first_r) begin
        first_x_r <= rd_x_r;
        first_y_r <= rd_y_r;
      end
    end
  end

  // Edge formation: A is the previous vertex, B the one just read or vertex zero.
  logic signed [CW-1:0] ax, ay, bx, by, mnx, mxx, mny, mxy;
  logic                 e_vld;

  assign e_vld = m_vld_r && !m_first_r;
  assign ax    = prev_x_r;
  assign ay    = prev_y_r;
  assign bx    = m_wrap_r ? first_x_r : rd_x_r;
  assign by    = m_wrap_r ? first_y_r : rd_y_r;
  assign mnx   = (ax < bx) ? ax : bx;
  assign mxx   = (ax > bx) ? ax : bx;
  assign mny   = (ay < by) ? ay : by;
  assign mxy   = (ay > by) ? ay : by;

  function automatic logic near_le(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                   logic [pip_pkg::CTOL_W-1:0] tol);
    logic signed [EW-1:0] d;
    logic signed [EW-1:0] t;
    d = EW'(a) - EW'(b);
    t = signed'(EW'(tol));
    return d < t;
  endfunction

  // Stage 1: differences and the compare-only tests.
  logic signed [DW-1:0] dxp_r, dyp_r, dxe_r, dye_r;
  logic s1_vld_r, s1_box_r, s1_flat_r, s1_span_r, s1_up_r;

  always_ff @(posedge clk) begin
    dxp_r     <= DW'(px_r) - DW'(ax);
    dyp_r     <= DW'(py_r) - DW'(ay);
    dxe_r     <= DW'(bx) - DW'(ax);
    dye_r     <= DW'(by) - DW'(ay);
    s1_box_r  <= near_le(mnx, px_r, coord_tol) && near_le(px_r, mxx, coord_tol) &&
                 near_le(mny, py_r, coord_tol) && near_le(py_r, mxy, coord_tol);
    s1_flat_r <= (ay == by);
    s1_span_r <= !((py_r < mny) || (py_r >= mxy));
    s1_up_r   <= (by > ay);
  end

  // Stage 2: the two cross products.
  logic signed [PW-1:0] p1_r, p2_r;
  logic s2_vld_r, s2_box_r, s2_flat_r, s2_span_r, s2_up_r;

  always_ff @(posedge clk) begin
    p1_r      <= dxp_r * dye_r;
    p2_r      <= dxe_r * dyp_r;
    s2_box_r  <= s1_box_r;
    s2_flat_r <= s1_flat_r;
    s2_span_r <= s1_span_r;
    s2_up_r   <= s1_up_r;
  end

  // Stage 3: product difference.
  logic signed [QW-1:0] c_r;
  logic s3_vld_r, s3_box_r, s3_flat_r, s3_span_r, s3_up_r;

  always_ff @(posedge clk) begin
    c_r       <= QW'(p1_r) - QW'(p2_r);
    s3_box_r  <= s2_box_r;
    s3_flat_r <= s2_flat_r;
    s3_span_r <= s2_span_r;
    s3_up_r   <= s2_up_r;
  end

  // Final tests on the difference.
  logic signed [XW-1:0] c_ext, tol_ext;
  logic                 hit, crossing;

  assign c_ext    = XW'(c_r);
  assign tol_ext  = signed'(XW'(cross_tol));
  assign hit      = s3_box_r && (c_ext < tol_ext) && (c_ext > -tol_ext);
  assign crossing = !s3_flat_r && s3_span_r &&
                    (s3_up_r ? (c_r < 0) : (c_r > 0));

  // Pipeline valids and accumulators.
  logic on_r, par_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r   <= 1'b0;
      m_first_r <= 1'b0;
      m_wrap_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      on_r      <= 1'b0;
      par_r     <= 1'b0;
    end else begin
      m_vld_r   <= cmd.rd_en || cmd.wrap;
      m_first_r <= cmd.rd_first;
      m_wrap_r  <= cmd.wrap;
      s1_vld_r  <= e_vld;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      if (cmd.q_start) begin
        on_r  <= 1'b0;
        par_r <= 1'b0;
      end else if (s3_vld_r) begin
        on_r  <= on_r | hit;
        par_r <= par_r ^ crossing;
      end
    end
  end

  assign sts.pipe_busy  = m_vld_r || s1_vld_r || s2_vld_r || s3_vld_r;
  assign sts.on_edge    = on_r;
  assign sts.inside_res = on_r || par_r;

endmodule

[hdl/point_in_polygon_test.sv]
// Top level of the point-in-polygon tester: configuration registers and the
// controller/datapath pair. Depends on pip_pkg, pip_ctrl and pip_dp.
//
// Usage. The input channel takes one beat per item. A load beat (kind 0)
// writes vertex_index with (coord_x, coord_y) into the vertex store and
// gives no result. A query beat (kind 1) tests the point against
// the polygon of the first vertex_count vertices and gives one result beat
// with inside_res and on_edge.
// Timing. A query walks one edge per cycle, through the single read port of
// the vertex store and a four-stage edge pipeline. An empty polygon skips
// the edge walk. The block works on one query at a time and holds in_stall
// high meanwhile; loads are taken every cycle while no query is in progress.
// The result sits in an output register; while out_stall is high it holds,
// and a query that finishes meanwhile waits for it to be taken.
// Reset (synchronous, rst_n low) empties the channels and restores the
// register defaults; the vertex store is not cleared and must be loaded
// before a query reads it. Configuration must be written over the APB-style port
// only while the block is idle; the block itself does not enforce this.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [5:0]                      in_vertex_index,
  input  logic signed [31:0]              in_coord_x,
  input  logic signed [31:0]              in_coord_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_inside_res,
  output logic                            out_on_edge,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pip_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pip_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pip_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  logic [pip_pkg::VCOUNT_W-1:0] vcount_r;
  logic [pip_pkg::XTOL_W-1:0]   xtol_r;
  logic [pip_pkg::CTOL_W-1:0]   ctol_r;
  logic [NW-1:0]                vcount_sat;
  logic [1:0]                   reg_idx;
  logic [AW-1:0]                rd_addr;
  pip_pkg::cmd_t                cmd;
  pip_pkg::sts_t                sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= pip_pkg::VCOUNT_RST;
      xtol_r   <= pip_pkg::XTOL_RST;
      ctol_r   <= pip_pkg::CTOL_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        pip_pkg::REG_VERTEX_COUNT:    vcount_r <= pwdata[pip_pkg::VCOUNT_W-1:0];
        pip_pkg::REG_CROSS_TOLERANCE: xtol_r   <= pwdata[pip_pkg::XTOL_W-1:0];
        pip_pkg::REG_COORD_TOLERANCE: ctol_r   <= pwdata[pip_pkg::CTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      pip_pkg::REG_VERTEX_COUNT:    prdata = pip_pkg::CFG_DATA_W'(vcount_r);
      pip_pkg::REG_CROSS_TOLERANCE: prdata = pip_pkg::CFG_DATA_W'(xtol_r);
      pip_pkg::REG_COORD_TOLERANCE: prdata = pip_pkg::CFG_DATA_W'(ctol_r);
      default:                      prdata = '0;
    endcase
  end

  // A count above the store size is clipped to the store size.
  assign vcount_sat = (int'(vcount_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_r);

  pip_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_kind        (in_kind),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inside_res (out_inside_res),
    .out_on_edge    (out_on_edge),
    .vcount         (vcount_sat),
    .rd_addr        (rd_addr),
    .cmd            (cmd),
    .sts            (sts)
  );

  pip_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .rd_addr         (rd_addr),
    .cross_tol       (xtol_r),
    .coord_tol       (ctol_r),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

[hdl/pip_chk.sv]
// Port-level checker for the point-in-polygon tester, bound to the top level.
// Depends on pip_pkg and point_in_polygon_test.
module pip_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_kind,
  input logic out_valid,
  input logic out_stall,
  input logic out_inside_res,
  input logic out_on_edge
);

  // Reset leaves no result beat pending and the input open.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat pending after reset");
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inside_res) && $stable(out_on_edge))
    else $error("stalled result beat changed");

  // A point on an edge always counts as inside.
  a_edge_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_on_edge |-> out_inside_res)
    else $error("on-edge result not inside");

  // An accepted query occupies the block on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == pip_pkg::KIND_QUERY) |=> in_stall)
    else $error("query accepted without occupying the block");

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_inside_res (out_inside_res),
  .out_on_edge    (out_on_edge)
);

[verif/pip_checker.sv]
// Checker for the point-in-polygon tester: watches the item, result and register ports,
// predicts each query verdict and compares it with the result beats.
// Depends on pip_pkg only.
module pip_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_kind,
  input  logic [5:0]                     in_vertex_index,
  input  logic signed [31:0]             in_coord_x,
  input  logic signed [31:0]             in_coord_y,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_inside_res,
  input  logic                           out_on_edge,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pip_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pip_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  input  logic                           drain,
  output int                             err_count
);

  typedef struct packed {
    logic inside_res;
    logic on_edge;
  } verdict_t;

  typedef logic signed [71:0] wide_t;

  // Shadow copy of the vertex store and the registers.
  longint shadow_x [64];
  longint shadow_y [64];
  logic [pip_pkg::VCOUNT_W-1:0] poly_count;
  logic [pip_pkg::XTOL_W-1:0]   xtol;
  logic [pip_pkg::CTOL_W-1:0]   ctol;
  verdict_t                     verdicts_due[$];

  initial err_count = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  function automatic wide_t widen(input longint v);
    wide_t w;
    w = v;
    return w;
  endfunction

  // True when a is at most b within the box tolerance.
  function automatic logic within_tol(input longint a, input longint b);
    return (a - b) < longint'({48'd0, ctol});
  endfunction

  // Walks the edges of the polygon: on-edge test first (a hit ends the walk), then the half-open ray test.
  function automatic verdict_t judge_point(input longint px, input longint py);
    verdict_t v;
    int n, j;
    int crossings;
    longint ax, ay, bx, by, dy;
    wide_t c, lhs, rhs;
    n = (poly_count > 64) ? 64 : int'(poly_count);
    crossings = 0;
    v = '0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 >= n) ? 0 : i + 1;
      ax = shadow_x[i];
      ay = shadow_y[i];
      bx = shadow_x[j];
      by = shadow_y[j];
      c = widen(px - ax) * widen(by - ay) - widen(bx - ax) * widen(py - ay);
      if (c < 0) c = -c;
      if (c < $signed({40'd0, xtol}) &&
          within_tol((ax < bx) ? ax : bx, px) && within_tol(px, (ax > bx) ? ax : bx) &&
          within_tol((ay < by) ? ay : by, py) && within_tol(py, (ay > by) ? ay : by)) begin
        v.inside_res = 1'b1;
        v.on_edge = 1'b1;
        return v;
      end
      if (ay == by) continue;
      if (py < ((ay < by) ? ay : by) || py >= ((ay > by) ? ay : by)) continue;
      dy = by - ay;
      lhs = widen(py - ay) * widen(bx - ax);
      rhs = widen(px - ax) * widen(dy);
      if (dy > 0 ? (rhs < lhs) : (lhs < rhs)) crossings++;
    end
    v.inside_res = crossings[0];
    return v;
  endfunction

  // Track register writes, vertex loads and query beats; compare result beats.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      poly_count <= pip_pkg::VCOUNT_RST;
      xtol <= pip_pkg::XTOL_RST;
      ctol <= pip_pkg::CTOL_RST;
      verdicts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          pip_pkg::REG_VERTEX_COUNT:    poly_count <= pwdata[pip_pkg::VCOUNT_W-1:0];
          pip_pkg::REG_CROSS_TOLERANCE: xtol <= pwdata[pip_pkg::XTOL_W-1:0];
          pip_pkg::REG_COORD_TOLERANCE: ctol <= pwdata[pip_pkg::CTOL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report("result beat with no query waiting");
        end else begin
          want = verdicts_due.pop_front();
          if (out_inside_res !== want.inside_res)
            report($sformatf("inside_res %b, expected %b", out_inside_res, want.inside_res));
          if (out_on_edge !== want.on_edge)
            report($sformatf("on_edge %b, expected %b", out_on_edge, want.on_edge));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == pip_pkg::KIND_LOAD) begin
          shadow_x[in_vertex_index] = longint'(in_coord_x);
          shadow_y[in_vertex_index] = longint'(in_coord_y);
        end else begin
          verdicts_due.push_back(judge_point(longint'(in_coord_x), longint'(in_coord_y)));
        end
      end
    end
  end

  // At the end of the run every query must have been answered.
  always @(posedge drain) begin
    while (verdicts_due.size() > 0) begin
      void'(verdicts_due.pop_front());
      report("query never answered");
    end
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the point-in-polygon tester: clock, reset, item and register
// stimulus, result-side stalls and the verdict. Depends on pip_pkg, pip_checker and the RTL.
module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_kind = pip_pkg::KIND_LOAD;
  logic [5:0] in_vertex_index = '0;
  logic signed [31:0] in_coord_x = '0;
  logic signed [31:0] in_coord_y = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pip_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [pip_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic drain = 1'b0;
  logic in_stall, out_valid, out_inside_res, out_on_edge, pready;
  logic [pip_pkg::CFG_DATA_W-1:0] prdata;
  int err_count;

  int cyc = 0;
  int queries_sent = 0;
  int results_seen = 0;
  int items_sent = 0;
  int poly_x [64];
  int poly_y [64];

  point_in_polygon_test u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_vertex_index, .in_coord_x,
    .in_coord_y, .out_valid, .out_stall, .out_inside_res, .out_on_edge,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pip_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_vertex_index, .in_coord_x,
    .in_coord_y, .out_valid, .out_stall, .out_inside_res, .out_on_edge,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .drain, .err_count
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle count and answered queries.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && out_valid && !out_stall) results_seen <= results_seen + 1;
  end

  // No idling on either side in this stretch of cycles.
  function automatic logic calm();
    return cyc >= 3000 && cyc < 7000;
  endfunction

  // Result side: random stalls plus one long hold-off, started while queries are
  // being offered, so the block backs up.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && cyc >= 8000 && in_valid && (in_kind == pip_pkg::KIND_QUERY)) begin
        held = 1'b1;
        hold = 600;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm() && ($urandom_range(99) < 19);
      end
    end
  end

  // Offer one beat, with random gaps ahead of it; valid stays up between beats.
  task automatic send(input logic kind, input int slot, input int x, input int y);
    while (!calm() && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_vertex_index <= slot[5:0];
    in_coord_x <= x;
    in_coord_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (kind == pip_pkg::KIND_QUERY) queries_sent++;
  endtask

  task automatic load_vertex(input int slot, input int x, input int y);
    poly_x[slot] = x;
    poly_y[slot] = y;
    send(pip_pkg::KIND_LOAD, slot, x, y);
  endtask

  task automatic query(input int x, input int y);
    send(pip_pkg::KIND_QUERY, 0, x, y);
  endtask

  // Register write between phases: drain the results, then let the block settle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    in_valid <= 1'b0;
    while (results_seen != queries_sent) @(negedge clk);
    repeat (80) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic int pick_coord(input int mode);
    case (mode)
      0: return ($urandom_range(0, 16) - 8) * 65536;
      1: return $signed($urandom) >>> $urandom_range(0, 24);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n, mode, slot, j, shape, vcnt;
    longint mx, my;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty polygon, a square, one vertex, extreme coordinates.
    query(32'sd5 <<< 16, 32'sd5 <<< 16);
    load_vertex(0, 0, 0);
    load_vertex(1, 10 <<< 16, 0);
    load_vertex(2, 10 <<< 16, 10 <<< 16);
    load_vertex(3, 0, 10 <<< 16);
    reg_write(pip_pkg::REG_VERTEX_COUNT, 4);
    query(5 <<< 16, 5 <<< 16);
    query(15 <<< 16, 5 <<< 16);
    query(5 <<< 16, 0);
    query(10 <<< 16, 10 <<< 16);
    query(-5 <<< 16, 5 <<< 16);
    query(32'h8000_0000, 32'h7fff_ffff);
    query(32'h7fff_ffff, 32'h8000_0000);
    query(3, 5 <<< 16);
    load_vertex(1, 32'h7fff_ffff, 32'h8000_0000);
    load_vertex(2, 32'h8000_0000, 32'h7fff_ffff);
    load_vertex(63, 32'h8000_0000, 32'h8000_0000);
    query(0, 0);
    query(32'h8000_0000, 32'h8000_0000);
    query(1 <<< 16, 1 <<< 16);
    reg_write(pip_pkg::REG_VERTEX_COUNT, 1);
    reg_write(pip_pkg::REG_COORD_TOLERANCE, 16'hffff);
    query(5, 5);
    query(32'h7fff_ffff, 32'h7fff_ffff);
    reg_write(pip_pkg::REG_CROSS_TOLERANCE, 0);
    reg_write(pip_pkg::REG_COORD_TOLERANCE, 0);
    query(0, 0);

    // Random phases: pick a setting, load a polygon, then query near its features.
    while (items_sent < 850) begin
      shape = $urandom_range(99);
      if (shape < 3) vcnt = 0;
      else if (shape < 10) vcnt = $urandom_range(1, 2);
      else if (shape < 80) vcnt = $urandom_range(3, 8);
      else if (shape < 92) vcnt = $urandom_range(9, 64);
      else if (shape < 95) vcnt = 64;
      else vcnt = $urandom_range(65, 127);
      n = (vcnt > 64) ? 64 : vcnt;
      case ($urandom_range(3))
        0: reg_write(pip_pkg::REG_CROSS_TOLERANCE, 0);
        1: reg_write(pip_pkg::REG_CROSS_TOLERANCE, 32'hffff_ffff);
        2: reg_write(pip_pkg::REG_CROSS_TOLERANCE, pip_pkg::XTOL_RST);
        default: reg_write(pip_pkg::REG_CROSS_TOLERANCE, $urandom);
      endcase
      case ($urandom_range(3))
        0: reg_write(pip_pkg::REG_COORD_TOLERANCE, 0);
        1: reg_write(pip_pkg::REG_COORD_TOLERANCE, 16'hffff);
        2: reg_write(pip_pkg::REG_COORD_TOLERANCE, pip_pkg::CTOL_RST);
        default: reg_write(pip_pkg::REG_COORD_TOLERANCE, $urandom_range(0, 65535));
      endcase
      reg_write(pip_pkg::REG_VERTEX_COUNT, vcnt);
      mode = ($urandom_range(99) < 60) ? 0 : ($urandom_range(99) < 70 ? 1 : 2);
      for (int i = 0; i < n; i++) load_vertex(i, pick_coord(mode), pick_coord(mode));
      // A stray load now and then to a random slot.
      if (n > 0 && $urandom_range(3) == 0) begin
        slot = $urandom_range(0, 63);
        load_vertex(slot, pick_coord(mode), pick_coord(mode));
      end
      if (n == 0) n = 1;
      repeat ($urandom_range(8, 20)) begin
        slot = $urandom_range(0, n - 1);
        j = (slot + 1 >= n) ? 0 : slot + 1;
        case ($urandom_range(5))
          0: query(poly_x[slot], poly_y[slot]);
          1: begin
            mx = (longint'(poly_x[slot]) + longint'(poly_x[j])) >>> 1;
            my = (longint'(poly_y[slot]) + longint'(poly_y[j])) >>> 1;
            query(int'(mx), int'(my));
          end
          2: query(pick_coord(mode) + $urandom_range(0, 1) * 32768,
                   pick_coord(mode) + $urandom_range(0, 1) * 32768);
          3: query(pick_coord(mode), poly_y[slot]);
          4: query(poly_x[slot] + int'($urandom_range(0, 16)) - 8,
                   poly_y[slot] + int'($urandom_range(0, 16)) - 8);
          default: query($urandom, $urandom);
        endcase
      end
    end

    in_valid <= 1'b0;
    while (results_seen != queries_sent) @(negedge clk);
    repeat (100) @(negedge clk);
    drain <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #3000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
